// ===== design/gfcs_pkg.sv =====
// Shared types and constants of the guided-filter coefficient solver.
package gfcs_pkg;

	localparam int VW     = 16;  // input field width
	localparam int EW     = 16;  // epsilon width
	localparam int OW     = 64;  // result field width
	localparam int MW     = 18;  // regularized matrix entry
	localparam int PW     = 36;  // product of two entries
	localparam int CW     = 37;  // cofactor
	localparam int TW     = 55;  // entry times cofactor
	localparam int NW     = 54;  // scaled cofactor (numerator)
	localparam int DW     = 56;  // determinant
	localparam int NMAG   = 51;  // numerator magnitude bits, also quotient bits
	localparam int DMAG   = 52;  // determinant magnitude bits
	localparam int QW     = NMAG + 2;  // signed quotient after sign fix
	localparam int NLANE  = 6;   // inverse entries
	localparam int SBW    = 3 * VW;  // covariance vector carried past the divider
	localparam int INV_SHIFT = 16;   // 65535 * c == (c << 16) - c

	localparam logic [EW-1:0] EPS_RESET = EW'(1);

	typedef struct packed {
		logic signed [VW-1:0] var_rr;
		logic signed [VW-1:0] var_rg;
		logic signed [VW-1:0] var_rb;
		logic signed [VW-1:0] var_gg;
		logic signed [VW-1:0] var_gb;
		logic signed [VW-1:0] var_bb;
		logic signed [VW-1:0] cov_red;
		logic signed [VW-1:0] cov_green;
		logic signed [VW-1:0] cov_blue;
	} pix_t;

	typedef struct packed {
		logic signed [OW-1:0] coef_red;
		logic signed [OW-1:0] coef_green;
		logic signed [OW-1:0] coef_blue;
	} coef_t;

	typedef logic signed [NW-1:0] num_t;
	typedef logic signed [QW-1:0] quo_t;

	// per-lane state of one divider stage
	typedef struct packed {
		logic [DMAG-1:0] rem;
		logic [NMAG-1:0] num;
		logic            sn;
	} div_lane_t;

	// shared state of one divider stage
	typedef struct packed {
		logic [DMAG-1:0] d;
		logic            sd;
		logic            dz;
		logic [SBW-1:0]  sb;
	} div_ctl_t;

endpackage

// ===== design/gfcs_div.sv =====
// Pipelined six-lane Euclidean divider sharing one divisor, one quotient bit per stage.
module gfcs_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic signed [gfcs_pkg::DW-1:0]  det,
	input  gfcs_pkg::num_t        num [gfcs_pkg::NLANE],
	input  logic [gfcs_pkg::SBW-1:0] sb_in,
	output logic                  out_vld,
	output gfcs_pkg::quo_t        quo [gfcs_pkg::NLANE],
	output logic [gfcs_pkg::SBW-1:0] sb_out
);
	import gfcs_pkg::*;

	logic      vld_s  [NMAG+1];
	div_ctl_t  ctl_s  [NMAG+1];
	div_lane_t lane_s [NMAG+1][NLANE];
	logic      vld_fx_q;
	logic [SBW-1:0] sb_fx_q;
	quo_t      quo_fx_q [NLANE];

	logic signed [DW-1:0] det_abs;
	assign det_abs = det[DW-1] ? -det : det;

	// prep: take magnitudes and signs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s[0].d  <= det_abs[DMAG-1:0];
			ctl_s[0].sd <= det[DW-1];
			ctl_s[0].dz <= (det == '0);
			ctl_s[0].sb <= sb_in;
			for (int l = 0; l < NLANE; l++) begin
				lane_s[0][l].rem <= '0;
				lane_s[0][l].num <= num[l][NW-1] ? NMAG'(-num[l]) : NMAG'(num[l]);
				lane_s[0][l].sn  <= num[l][NW-1];
			end
		end
	end

	// restoring division, most significant quotient bit first
	for (genvar k = 0; k < NMAG; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k+1].d  <= ctl_s[k].d;
				ctl_s[k+1].sd <= ctl_s[k].sd;
				ctl_s[k+1].dz <= ctl_s[k].dz;
				ctl_s[k+1].sb <= ctl_s[k].sb;
			end
		end

		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			logic [DMAG:0] rin;
			logic [DMAG:0] diff;
			logic          ge;
			assign rin  = {lane_s[k][l].rem, lane_s[k][l].num[NMAG-1]};
			assign diff = rin - {1'b0, ctl_s[k].d};
			assign ge   = !diff[DMAG];

			always_ff @(posedge clk) begin
				if (en) begin
					lane_s[k+1][l].rem <= ge ? diff[DMAG-1:0] : rin[DMAG-1:0];
					lane_s[k+1][l].num <= {lane_s[k][l].num[NMAG-2:0], ge};
					lane_s[k+1][l].sn  <= lane_s[k][l].sn;
				end
			end
		end
	end

	// fix up: Euclidean rounding, sign, zero divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_fx_q <= 1'b0;
		end else if (en) begin
			vld_fx_q <= vld_s[NMAG];
		end
	end

	always_ff @(posedge clk) begin
		logic [QW-1:0] qm;
		if (en) begin
			sb_fx_q <= ctl_s[NMAG].sb;
			for (int l = 0; l < NLANE; l++) begin
				qm = QW'(lane_s[NMAG][l].num)
					+ QW'(lane_s[NMAG][l].sn && (lane_s[NMAG][l].rem != '0));
				if (ctl_s[NMAG].dz) begin
					quo_fx_q[l] <= '0;
				end else if (lane_s[NMAG][l].sn ^ ctl_s[NMAG].sd) begin
					quo_fx_q[l] <= -$signed(qm);
				end else begin
					quo_fx_q[l] <= $signed(qm);
				end
			end
		end
	end

	assign out_vld = vld_fx_q;
	assign sb_out  = sb_fx_q;
	assign quo     = quo_fx_q;

endmodule

// ===== design/guided_filter_coef_solve.sv =====
// Top level of the guided-filter coefficient solver.
//
// Channels: pixel beats enter on pix (pix_valid/pix_ready) carrying the six
// distinct entries of the symmetric 3x3 guide covariance matrix and the three
// guide-to-input covariances. Coefficient beats leave on coef
// (coef_valid/coef_ready) with the three slope coefficients, scaled by 65535
// and wrapping at 64 bits. The cfg channel writes epsilon; cfg_ready is
// always high. Write it only while the pipeline is empty.
//
// Throughput: one beat per cycle while the output is not stalled. From accept to
// coef_valid a beat passes the stages forming the determinant and scaled
// cofactors, the divider (magnitude prep, one quotient bit per stage over 51
// stages, sign fix), one multiply and one add stage.
//
// Reset clears every valid bit and sets epsilon to 1. When the receiver
// holds coef_ready low with a beat waiting, the whole pipeline freezes,
// bubbles included, and pix_ready drops; nothing is lost or repeated.
module guided_filter_coef_solve (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [gfcs_pkg::EW-1:0]   cfg_data,
	input  logic                      pix_valid,
	output logic                      pix_ready,
	input  gfcs_pkg::pix_t            pix,
	output logic                      coef_valid,
	input  logic                      coef_ready,
	output gfcs_pkg::coef_t           coef
);
	import gfcs_pkg::*;

	logic [EW-1:0] eps_q;
	logic          en;

	// advance everything unless a finished beat is stuck at the output
	assign en        = !coef_valid || coef_ready;
	assign pix_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_valid) begin
			eps_q <= cfg_data;
		end
	end

	// stage 1: regularize the diagonal
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [MW-1:0] ma_s1, mb_s1, mc_s1, md_s1, me_s1, mf_s1;
	logic [SBW-1:0] v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [MW-1:0] eps_ext;
	assign eps_ext = $signed({{(MW-EW){1'b0}}, eps_q});

	// stage 2: pairwise products
	logic signed [MW-1:0] ma_s2, mb_s2, mc_s2;
	logic signed [PW-1:0] p_dmf_s2, p_ee_s2, p_bmf_s2, p_cme_s2, p_bme_s2, p_cmd_s2;
	logic signed [PW-1:0] p_amf_s2, p_cc_s2, p_ame_s2, p_bmc_s2, p_amd_s2, p_bb_s2;

	// stage 3: cofactors
	logic signed [MW-1:0] ma_s3, mb_s3, mc_s3;
	logic signed [CW-1:0] c_s3 [NLANE];

	// stage 4: first-row terms of the determinant, scaled cofactors
	logic signed [TW-1:0] t0_s4, t1_s4, t2_s4;
	num_t n_s4 [NLANE];

	// stage 5: determinant
	logic signed [DW-1:0] det_s5;
	num_t n_s5 [NLANE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pix_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1 <= MW'(pix.var_rr) + eps_ext;
			mb_s1 <= MW'(pix.var_rg);
			mc_s1 <= MW'(pix.var_rb);
			md_s1 <= MW'(pix.var_gg) + eps_ext;
			me_s1 <= MW'(pix.var_gb);
			mf_s1 <= MW'(pix.var_bb) + eps_ext;
			v_s1  <= {pix.cov_red, pix.cov_green, pix.cov_blue};

			ma_s2    <= ma_s1;
			mb_s2    <= mb_s1;
			mc_s2    <= mc_s1;
			v_s2     <= v_s1;
			p_dmf_s2 <= PW'(md_s1) * PW'(mf_s1);
			p_ee_s2  <= PW'(me_s1) * PW'(me_s1);
			p_bmf_s2 <= PW'(mb_s1) * PW'(mf_s1);
			p_cme_s2 <= PW'(mc_s1) * PW'(me_s1);
			p_bme_s2 <= PW'(mb_s1) * PW'(me_s1);
			p_cmd_s2 <= PW'(mc_s1) * PW'(md_s1);
			p_amf_s2 <= PW'(ma_s1) * PW'(mf_s1);
			p_cc_s2  <= PW'(mc_s1) * PW'(mc_s1);
			p_ame_s2 <= PW'(ma_s1) * PW'(me_s1);
			p_bmc_s2 <= PW'(mb_s1) * PW'(mc_s1);
			p_amd_s2 <= PW'(ma_s1) * PW'(md_s1);
			p_bb_s2  <= PW'(mb_s1) * PW'(mb_s1);

			ma_s3   <= ma_s2;
			mb_s3   <= mb_s2;
			mc_s3   <= mc_s2;
			v_s3    <= v_s2;
			c_s3[0] <= CW'(p_dmf_s2) - CW'(p_ee_s2);
			c_s3[1] <= CW'(p_cme_s2) - CW'(p_bmf_s2);
			c_s3[2] <= CW'(p_bme_s2) - CW'(p_cmd_s2);
			c_s3[3] <= CW'(p_amf_s2) - CW'(p_cc_s2);
			c_s3[4] <= CW'(p_bmc_s2) - CW'(p_ame_s2);
			c_s3[5] <= CW'(p_amd_s2) - CW'(p_bb_s2);

			v_s4  <= v_s3;
			t0_s4 <= TW'(ma_s3) * TW'(c_s3[0]);
			t1_s4 <= TW'(mb_s3) * TW'(c_s3[1]);
			t2_s4 <= TW'(mc_s3) * TW'(c_s3[2]);
			for (int l = 0; l < NLANE; l++) begin
				// scale by 65535 as shift and subtract
				n_s4[l] <= (NW'(c_s3[l]) <<< INV_SHIFT) - NW'(c_s3[l]);
			end

			v_s5   <= v_s4;
			det_s5 <= DW'(t0_s4) + DW'(t1_s4) + DW'(t2_s4);
			n_s5   <= n_s4;
		end
	end

	// inverse entries
	logic           vld_dv;
	quo_t           q_dv [NLANE];
	logic [SBW-1:0] v_dv;

	gfcs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s5),
		.det     (det_s5),
		.num     (n_s5),
		.sb_in   (v_s5),
		.out_vld (vld_dv),
		.quo     (q_dv),
		.sb_out  (v_dv)
	);

	// multiply stage: inverse times covariance vector, wrapping at 64 bits
	logic signed [OW-1:0] vx, vy, vz;
	assign vx = OW'($signed(v_dv[3*VW-1:2*VW]));
	assign vy = OW'($signed(v_dv[2*VW-1:VW]));
	assign vz = OW'($signed(v_dv[VW-1:0]));

	logic vld_mul_q;
	logic signed [OW-1:0] r0_q, r1_q, r2_q, g0_q, g1_q, g2_q, b0_q, b1_q, b2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_mul_q  <= 1'b0;
			coef_valid <= 1'b0;
		end else if (en) begin
			vld_mul_q  <= vld_dv;
			coef_valid <= vld_mul_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r0_q <= OW'(q_dv[0]) * vx;
			r1_q <= OW'(q_dv[1]) * vy;
			r2_q <= OW'(q_dv[2]) * vz;
			g0_q <= OW'(q_dv[1]) * vx;
			g1_q <= OW'(q_dv[3]) * vy;
			g2_q <= OW'(q_dv[4]) * vz;
			b0_q <= OW'(q_dv[2]) * vx;
			b1_q <= OW'(q_dv[4]) * vy;
			b2_q <= OW'(q_dv[5]) * vz;

			// output register: hold while the receiver stalls
			coef.coef_red   <= r0_q + r1_q + r2_q;
			coef.coef_green <= g0_q + g1_q + g2_q;
			coef.coef_blue  <= b0_q + b1_q + b2_q;
		end
	end

endmodule

// ===== design/gfcs_chk.sv =====
// Port-level checker for the guided-filter coefficient solver, with its bind.
module gfcs_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            pix_ready,
	input logic            coef_valid,
	input logic            coef_ready,
	input gfcs_pkg::coef_t coef
);
	import gfcs_pkg::*;

	// stalled output beat holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(coef_valid && !coef_ready) |=> (coef_valid && $stable(coef)))
		else $error("coef beat changed while stalled");

	// input side stalls exactly when the output is stuck
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready == (!coef_valid || coef_ready))
		else $error("pix_ready does not follow output stall");

	// reset empties the output
	a_rst: assert property (@(posedge clk) !arst_n |-> !coef_valid)
		else $error("coef_valid high during reset");

endmodule

bind guided_filter_coef_solve gfcs_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_ready  (pix_ready),
	.coef_valid (coef_valid),
	.coef_ready (coef_ready),
	.coef       (coef)
);
